>>> rtl/core/rpnc_pkg.sv
// ----------------------------------------------------------------------------
// rpnc_pkg
// Shared types and codes for the RPN stack calculator core.
// ----------------------------------------------------------------------------
package rpnc_pkg;

  // Width of one stack entry and of the operand and result fields.
  localparam int DATA_W = 64;
  // Step counter width of the multi-cycle arithmetic unit.
  localparam int STEP_W = $clog2(DATA_W);

  // Request codes.
  localparam logic [2:0] REQ_PUSH   = 3'd0;
  localparam logic [2:0] REQ_ADD    = 3'd1;
  localparam logic [2:0] REQ_SUB    = 3'd2;
  localparam logic [2:0] REQ_MUL    = 3'd3;
  localparam logic [2:0] REQ_DIV    = 3'd4;
  localparam logic [2:0] REQ_FINISH = 3'd5;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_LEFTOVER  = 3'd4;

  // Request to the multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

  // Response from the multiply/divide unit.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } mdu_rsp_t;

endpackage

>>> rtl/core/rpnc_muldiv.sv
// ----------------------------------------------------------------------------
// rpnc_muldiv
// Multi-cycle 64-bit multiply (low half) and signed truncating divide.
// ----------------------------------------------------------------------------
module rpnc_muldiv
  import rpnc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mdu_req_t          req,
  input  logic [DATA_W-1:0] op_a,
  input  logic [DATA_W-1:0] op_b,
  output mdu_rsp_t          rsp
);

  localparam int HALF_W = DATA_W / 2;
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(2);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DATA_W - 1);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_FIX  = 4'b1000
  } ustate_t;

  ustate_t           ustate_r, ustate_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  // In a multiply these hold the operands; in a divide opa_r shifts the
  // numerator magnitude out and the quotient bits in, opb_r is the divisor.
  logic [DATA_W-1:0] opa_r, opa_nxt;
  logic [DATA_W-1:0] opb_r, opb_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;

  logic [HALF_W-1:0] mul_x, mul_y;
  logic [DATA_W-1:0] prod;
  logic [DATA_W:0]   trial;

  // Shared 32x32 partial product.
  always_comb begin
    case (step_r[1:0])
      2'd0: begin
        mul_x = opa_r[HALF_W-1:0];
        mul_y = opb_r[HALF_W-1:0];
      end
      2'd1: begin
        mul_x = opa_r[HALF_W-1:0];
        mul_y = opb_r[DATA_W-1:HALF_W];
      end
      default: begin
        mul_x = opa_r[DATA_W-1:HALF_W];
        mul_y = opb_r[HALF_W-1:0];
      end
    endcase
  end

  assign prod = mul_x * mul_y;

  // One restoring division step.
  assign trial = {rem_r, opa_r[DATA_W-1]} - {1'b0, opb_r};

  // Sequencer of the unit.
  always_comb begin
    ustate_nxt = ustate_r;
    step_nxt   = step_r;
    done_nxt   = 1'b0;
    neg_nxt    = neg_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    rem_nxt    = rem_r;
    acc_nxt    = acc_r;
    case (ustate_r)
      U_IDLE: begin
        if (req.start) begin
          step_nxt = '0;
          if (req.is_div) begin
            // Work on magnitudes; the sign is applied at the end.
            opa_nxt    = op_a[DATA_W-1] ? (DATA_W'(0) - op_a) : op_a;
            opb_nxt    = op_b[DATA_W-1] ? (DATA_W'(0) - op_b) : op_b;
            neg_nxt    = op_a[DATA_W-1] ^ op_b[DATA_W-1];
            rem_nxt    = '0;
            ustate_nxt = U_DIV;
          end else begin
            opa_nxt    = op_a;
            opb_nxt    = op_b;
            ustate_nxt = U_MUL;
          end
        end
      end
      U_MUL: begin
        // Low half only: lo*lo, then both cross terms shifted up.
        if (step_r == '0) begin
          acc_nxt = prod;
        end else begin
          acc_nxt = acc_r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == MUL_LAST) begin
          done_nxt   = 1'b1;
          ustate_nxt = U_IDLE;
        end
      end
      U_DIV: begin
        if (!trial[DATA_W]) begin
          rem_nxt = trial[DATA_W-1:0];
          opa_nxt = {opa_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DATA_W-2:0], opa_r[DATA_W-1]};
          opa_nxt = {opa_r[DATA_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_LAST) begin
          ustate_nxt = U_FIX;
        end
      end
      U_FIX: begin
        acc_nxt    = neg_r ? (DATA_W'(0) - opa_r) : opa_r;
        done_nxt   = 1'b1;
        ustate_nxt = U_IDLE;
      end
      default: begin
        ustate_nxt = U_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ustate_r <= U_IDLE;
      done_r   <= 1'b0;
    end else begin
      ustate_r <= ustate_nxt;
      done_r   <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = acc_r;

endmodule

>>> rtl/core/rpn_stack_calculator_core.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core
// Reverse Polish evaluator on a stack of 64-bit signed entries in one RAM.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                                        Handshake
// request   in         in_req_type, in_operand_value                start & !busy
// result    out        out_status, out_result_valid, out_result_value  out_strobe
//
// Every accepted transaction gives one result, strobed for one cycle.
// Push, errors found at accept, finish on an empty stack and unused codes end
// in the accept state. Finish reads the top entry first. Add, subtract and a
// divide by zero read twice from the single stack RAM read port; add and
// subtract then write back. Multiply forms three 32x32 partial products;
// divide makes one quotient bit per cycle. Reset clears the count, not the RAM.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core
  import rpnc_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_req_type,
  input  logic signed [DATA_W-1:0] in_operand_value,
  output logic                     out_strobe,
  output logic [2:0]               out_status,
  output logic                     out_result_valid,
  output logic signed [DATA_W-1:0] out_result_value
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD_B = 5'b00010,
    S_RD_A = 5'b00100,
    S_EXEC = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic              strobe_r, strobe_nxt;
  logic [2:0]        status_r, status_nxt;
  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd;

  logic [CW-1:0]     top_cnt, sec_cnt;
  logic [AW-1:0]     top_idx, sec_idx;
  mdu_req_t          mdu_req;
  mdu_rsp_t          mdu_rsp;

  assign top_cnt = count_r - CW'(1);
  assign sec_cnt = count_r - CW'(2);
  assign top_idx = top_cnt[AW-1:0];
  assign sec_idx = sec_cnt[AW-1:0];

  rpnc_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .op_a  (rd_data_r),
    .op_b  (b_r),
    .rsp   (mdu_rsp)
  );

  // Request sequencer: reads operands, applies the operator, writes back.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    req_nxt    = req_r;
    b_nxt      = b_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    valid_nxt  = 1'b0;
    value_nxt  = '0;
    mem_we     = 1'b0;
    mem_wa     = sec_idx;
    mem_wd     = '0;
    mem_ra     = top_idx;
    mdu_req    = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req_type;
          case (in_req_type)
            REQ_PUSH: begin
              strobe_nxt = 1'b1;
              if (count_r >= CW'(STACK_DEPTH)) begin
                status_nxt = ST_OVERFLOW;
                count_nxt  = '0;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = count_r[AW-1:0];
                mem_wd    = in_operand_value;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
              if (count_r < CW'(2)) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_UNDERFLOW;
                count_nxt  = '0;
              end else begin
                // The top entry is read at this edge.
                state_nxt = S_RD_B;
              end
            end
            REQ_FINISH: begin
              if (count_r == '0) begin
                strobe_nxt = 1'b1;
              end else begin
                state_nxt = S_FIN;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_RD_B: begin
        b_nxt     = rd_data_r;
        mem_ra    = sec_idx;
        state_nxt = S_RD_A;
      end
      S_RD_A: begin
        // The entry below the top is on the read port now.
        case (req_r)
          REQ_ADD, REQ_SUB: begin
            mem_we     = 1'b1;
            mem_wd     = (req_r == REQ_ADD) ? (rd_data_r + b_r) : (rd_data_r - b_r);
            count_nxt  = count_r - CW'(1);
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
          REQ_MUL: begin
            mdu_req.start = 1'b1;
            state_nxt     = S_EXEC;
          end
          REQ_DIV: begin
            if (b_r == '0) begin
              status_nxt = ST_DIVZERO;
              count_nxt  = '0;
              strobe_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              mdu_req.start  = 1'b1;
              mdu_req.is_div = 1'b1;
              state_nxt      = S_EXEC;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_EXEC: begin
        if (mdu_rsp.done) begin
          mem_we     = 1'b1;
          mem_wd     = mdu_rsp.value;
          count_nxt  = count_r - CW'(1);
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FIN: begin
        strobe_nxt = 1'b1;
        valid_nxt  = 1'b1;
        value_nxt  = rd_data_r;
        status_nxt = (count_r > CW'(1)) ? ST_LEFTOVER : ST_OK;
        count_nxt  = '0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Stack RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= stack_mem[mem_ra];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    b_r      <= b_nxt;
    status_r <= status_nxt;
    valid_r  <= valid_nxt;
    value_r  <= value_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_result_valid = valid_r;
  assign out_result_value = value_r;

endmodule

>>> rtl/core/rpnc_checker.sv
// ----------------------------------------------------------------------------
// rpnc_checker
// Port-level checks of the RPN stack calculator core, bound to the core module.
// ----------------------------------------------------------------------------
module rpnc_checker
  import rpnc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic [2:0]        out_status,
  input logic              out_result_valid,
  input logic [DATA_W-1:0] out_result_value
);

  // A result only follows an accepted transaction or work in progress.
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) || $past(start && !busy)))
    else $error("result strobe without a pending transaction");

  // The busy interval of one transaction ends with a result.
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    (busy ##1 !busy) |-> out_strobe)
    else $error("busy ended without a result");

  // A result without a value carries zero.
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result_valid) |-> (out_result_value == '0))
    else $error("nonzero value in a result without a value");

  // A popped value comes only with ok or leftover status.
  a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_valid) |->
      (out_status == ST_OK || out_status == ST_LEFTOVER))
    else $error("popped value with an error status");

endmodule

bind rpn_stack_calculator_core rpnc_checker u_rpnc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_status       (out_status),
  .out_result_valid (out_result_valid),
  .out_result_value (out_result_value)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RPN stack calculator core. A short table of
// tokens covers the field extremes, every request code and each error path.
// It is followed by random expressions, broken sequences and noise at three
// sender idle rates. Every result is compared against its table entry or a
// behavioral stack predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rpnc_pkg::*;

  localparam int STACK_DEPTH = 128;
  // Even a run of nothing but divides takes well under a fifth of this.
  localparam int RUN_LIMIT_NS = 2_000_000;
  // Cycles to wait after the last result; covers the divide latency.
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 640;

  // Request codes the core ignores.
  localparam logic [2:0] REQ_RSVD_LO = 3'd6;
  localparam logic [2:0] REQ_RSVD_HI = 3'd7;

  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VAL_NEG1 = '1;

  // One result as it appears on the output ports.
  typedef struct packed {
    logic [2:0]        status;
    logic              valid;
    logic [DATA_W-1:0] value;
  } result_t;

  // One token to send; has_want marks a result typed into the table.
  typedef struct packed {
    logic [2:0]        req;
    logic [DATA_W-1:0] val;
    logic [7:0]        reps;
    logic              has_want;
    result_t           want;
  } token_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [2:0]               in_req_type = '0;
  logic signed [DATA_W-1:0] in_operand_value = '0;
  logic                     out_strobe;
  logic [2:0]               out_status;
  logic                     out_result_valid;
  logic signed [DATA_W-1:0] out_result_value;

  // Token currently on the input ports, updated together with them.
  token_t cur_token = '0;

  // Predictor state.
  logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
  int                calc_depth = 0;

  result_t pending_results [$];
  token_t  directed_tokens [$];
  int      error_count = 0;
  int      items_sent = 0;
  int      sender_idle_pct = 0;

  rpn_stack_calculator_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_operand_value(in_operand_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_result_valid(out_result_valid),
    .out_result_value(out_result_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  // Applies one token to the predicted stack and returns the expected result.
  function automatic result_t eval_token(input logic [2:0] req,
                                         input logic [DATA_W-1:0] val);
    result_t           res;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] quot;
    res = '0;
    case (req)
      REQ_PUSH: begin
        if (calc_depth >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
          calc_depth = 0;
        end else begin
          calc_stack[calc_depth] = val;
          calc_depth++;
        end
      end
      REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
        if (calc_depth < 2) begin
          res.status = ST_UNDERFLOW;
          calc_depth = 0;
        end else begin
          b = calc_stack[calc_depth-1];
          a = calc_stack[calc_depth-2];
          if (req == REQ_DIV && b == '0) begin
            res.status = ST_DIVZERO;
            calc_depth = 0;
          end else begin
            case (req)
              REQ_ADD: r = a + b;
              REQ_SUB: r = a - b;
              REQ_MUL: r = a * b;
              default: begin
                // Divide magnitudes, then fix the sign: truncates toward zero.
                mag_a = a[DATA_W-1] ? ('0 - a) : a;
                mag_b = b[DATA_W-1] ? ('0 - b) : b;
                quot = mag_a / mag_b;
                r = (a[DATA_W-1] ^ b[DATA_W-1]) ? ('0 - quot) : quot;
              end
            endcase
            calc_stack[calc_depth-2] = r;
            calc_depth--;
          end
        end
      end
      REQ_FINISH: begin
        if (calc_depth > 0) begin
          res.value = calc_stack[calc_depth-1];
          res.valid = 1'b1;
          if (calc_depth > 1) res.status = ST_LEFTOVER;
        end
        calc_depth = 0;
      end
      default: begin
        // Unused codes leave the stack alone.
      end
    endcase
    return res;
  endfunction

  // Mix of extremes, small values and full-width random numbers.
  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return VAL_NEG1;
      4, 5: return DATA_W'($signed($urandom_range(20)) - 10);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic token_t make_token(input logic [2:0] req,
                                        input logic [DATA_W-1:0] val);
    token_t t;
    t = '0;
    t.req = req;
    t.val = val;
    t.reps = 8'd1;
    return t;
  endfunction

  task automatic add_directed(input logic [2:0] req, input logic [DATA_W-1:0] val,
                              input int reps, input logic has_want,
                              input logic [2:0] st, input logic vld,
                              input logic [DATA_W-1:0] value);
    token_t t;
    t = make_token(req, val);
    t.reps = 8'(reps);
    t.has_want = has_want;
    t.want.status = st;
    t.want.valid = vld;
    t.want.value = value;
    directed_tokens.push_back(t);
  endtask

  // Drives one token, idling first in the given share of cycles, and waits
  // for accept.
  task automatic send_token(input token_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= t.req;
    in_operand_value <= t.val;
    cur_token <= t;
    @(posedge clk);
    while (!(start && !busy)) @(posedge clk);
    if (t.req <= REQ_FINISH) items_sent++;
  endtask

  // Sends a well-formed expression of random shape, ending with finish.
  // Extra pushes ahead of it leave entries over when finish comes.
  task automatic send_expression(input int extra);
    int     n_operands;
    int     pushed;
    int     depth;
    int     pick;
    logic [2:0] op;
    n_operands = $urandom_range(1, 6);
    pushed = 0;
    depth = 0;
    repeat (extra) send_token(make_token(REQ_PUSH, random_operand()));
    while (pushed < n_operands || depth > 1) begin
      if (pushed < n_operands && (depth < 2 || $urandom_range(1) == 0)) begin
        send_token(make_token(REQ_PUSH, random_operand()));
        pushed++;
        depth++;
      end else begin
        pick = $urandom_range(9);
        op = (pick < 3) ? REQ_ADD : (pick < 6) ? REQ_SUB : (pick < 8) ? REQ_MUL : REQ_DIV;
        send_token(make_token(op, random_operand()));
        depth--;
      end
    end
    send_token(make_token(REQ_FINISH, random_operand()));
  endtask

  // Predicts on every accepted transaction and checks every strobed result.
  always @(posedge clk) begin : scoreboard
    result_t predicted;
    result_t want;
    if (rst_n) begin
      if (start && !busy) begin
        predicted = eval_token(in_req_type, in_operand_value);
        pending_results.push_back(cur_token.has_want ? cur_token.want : predicted);
      end
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no transaction pending: status %0d", $time,
                   out_status);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_status);
            error_count++;
          end
          if (out_result_valid !== want.valid) begin
            $display("%0t: result_valid expected %0d actual %0d", $time, want.valid,
                     out_result_valid);
            error_count++;
          end
          if (out_result_value !== want.value) begin
            $display("%0t: result_value expected %0d actual %0d", $time,
                     $signed(want.value), out_result_value);
            error_count++;
          end
        end
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    token_t t;
    int     phase;
    int     pick;
    int     k;
    logic   filled;

    // Directed table. Finish on empty, operators without operands, the
    // wrapping add and MIN/-1, divide by zero, leftovers, unused codes, and
    // a full stack followed by one push too many.
    add_directed(REQ_FINISH, '0, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_ADD, VAL_NEG1, 1, 1, ST_UNDERFLOW, 1'b0, '0);
    add_directed(REQ_PUSH, VAL_MAX, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_SUB, '0, 1, 1, ST_UNDERFLOW, 1'b0, '0);
    add_directed(REQ_PUSH, VAL_MAX, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, 64'd1, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_ADD, '0, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_FINISH, '0, 1, 1, ST_OK, 1'b1, VAL_MIN);
    add_directed(REQ_PUSH, VAL_MIN, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, VAL_NEG1, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_DIV, '0, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_FINISH, '0, 1, 1, ST_OK, 1'b1, VAL_MIN);
    add_directed(REQ_PUSH, -64'sd7, 1, 0, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, 64'd2, 1, 0, ST_OK, 1'b0, '0);
    add_directed(REQ_DIV, '0, 1, 0, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, 64'd3, 1, 0, ST_OK, 1'b0, '0);
    add_directed(REQ_MUL, '0, 1, 0, ST_OK, 1'b0, '0);
    add_directed(REQ_FINISH, '0, 1, 0, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, 64'd7, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, '0, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_DIV, '0, 1, 1, ST_DIVZERO, 1'b0, '0);
    add_directed(REQ_FINISH, '0, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, 64'd1, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, 64'd2, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_FINISH, '0, 1, 1, ST_LEFTOVER, 1'b1, 64'd2);
    add_directed(REQ_RSVD_LO, VAL_NEG1, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_RSVD_HI, VAL_MIN, 1, 1, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, '0, STACK_DEPTH, 0, ST_OK, 1'b0, '0);
    add_directed(REQ_PUSH, VAL_MAX, 1, 1, ST_OVERFLOW, 1'b0, '0);
    add_directed(REQ_MUL, '0, 1, 1, ST_UNDERFLOW, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; repeated rows push random values to fill the stack.
    sender_idle_pct = 35;
    foreach (directed_tokens[i]) begin
      t = directed_tokens[i];
      for (k = 0; k < int'(t.reps); k++) begin
        if (t.reps > 1) t.val = random_operand();
        send_token(t);
      end
    end

    // Random part in three phases of sender idling.
    items_sent = 0;
    filled = 1'b0;
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 62 : 0;
      while (items_sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        pick = $urandom_range(99);
        if (phase == 1 && !filled) begin
          // Fill the stack, then either overflow it or finish with leftovers.
          filled = 1'b1;
          repeat (STACK_DEPTH) send_token(make_token(REQ_PUSH, random_operand()));
          send_token(make_token($urandom_range(1) ? REQ_PUSH : REQ_FINISH,
                                random_operand()));
        end else if (pick < 70) begin
          send_expression(0);
        end else if (pick < 82) begin
          send_expression($urandom_range(1, 3));
        end else begin
          repeat ($urandom_range(1, 4))
            send_token(make_token(3'($urandom_range(7)), {$urandom, $urandom}));
        end
      end
    end

    // Drain: wait for the last results, then a little longer for strays.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
